>>> rtl/pcfs_pkg.sv
`default_nettype none
package pcfs_pkg;

  localparam int ROM_SIZE  = 19;
  localparam int ROM_IDX_W = 5;
  localparam int MAX_OUT   = 4;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_LIMIT = 4'd1;

  localparam logic [10:0] ID_ENGINE  = 11'h186;
  localparam logic [10:0] ID_STATE   = 11'h1F6;
  localparam logic [10:0] ID_SPEED   = 11'h217;
  localparam logic [10:0] ID_COOLANT = 11'h5DA;
  localparam logic [10:0] ID_INTAKE  = 11'h65C;

  localparam logic [14:0] SPEED_MAX   = 15'd32000;
  localparam logic [29:0] SPEED_GAIN  = 30'd16712;
  localparam logic [14:0] SPEED_BIAS  = 15'd125;
  localparam logic [12:0] RAW_MAX     = 13'd4095;
  localparam logic [11:0] IDLE_MAX    = 12'd2040;
  localparam logic [13:0] REV_MAX     = 14'd8160;
  localparam logic [7:0]  SPEED_FLAG  = 8'h70;
  localparam logic [7:0]  STATE_MASK  = 8'h3F;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0]      period;
    logic [7:0]      phase;
    logic [7:0][7:0] base;
  } rom_entry_t;

  typedef struct packed {
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } frame_t;

  typedef struct packed {
    logic [15:0]        q3;
    logic               running;
    logic signed [8:0]  clt;
    logic               cval;
    logic signed [8:0]  iat;
    logic               ival;
    logic [11:0]        idle;
  } sensor_t;

  typedef struct packed {
    logic clear;
    logic update;
    logic advance;
  } phase_ctrl_t;

  function automatic rom_entry_t mk(input logic [10:0] id, input logic [3:0] len,
                                    input logic [7:0] period, input logic [7:0] phase,
                                    input logic [63:0] base);
    rom_entry_t e;
    e.id     = id;
    e.len    = len;
    e.period = period;
    e.phase  = phase;
    e.base   = base;
    return e;
  endfunction

  function automatic rom_entry_t rom_entry(input logic [ROM_IDX_W-1:0] idx);
    rom_entry_t e;
    case (idx)
      5'd0:    e = mk(11'h186, 4'd7, 8'd2,   8'd0,  64'h00200020_03320000);
      5'd1:    e = mk(11'h189, 4'd8, 8'd2,   8'd1,  64'h0000B900_32200332);
      5'd2:    e = mk(11'h18A, 4'd6, 8'd2,   8'd0,  64'h000000FE_06000032);
      5'd3:    e = mk(11'h1F6, 4'd8, 8'd2,   8'd1,  64'h00000000_2E020000);
      5'd4:    e = mk(11'h217, 4'd8, 8'd4,   8'd0,  64'h88000000_00000000);
      5'd5:    e = mk(11'h2A9, 4'd1, 8'd4,   8'd1,  64'h00000000_000000F4);
      5'd6:    e = mk(11'h2C6, 4'd6, 8'd4,   8'd2,  64'h00000000_40000000);
      5'd7:    e = mk(11'h36E, 4'd4, 8'd20,  8'd3,  64'h00000000_99099909);
      5'd8:    e = mk(11'h3A5, 4'd3, 8'd20,  8'd4,  64'h00000000_00000000);
      5'd9:    e = mk(11'h41A, 4'd8, 8'd20,  8'd5,  64'h00000000_00000300);
      5'd10:   e = mk(11'h41D, 4'd4, 8'd20,  8'd6,  64'h00000000_00FFFE48);
      5'd11:   e = mk(11'h511, 4'd7, 8'd20,  8'd7,  64'h00000000_00000000);
      5'd12:   e = mk(11'h522, 4'd8, 8'd20,  8'd8,  64'h00000000_00000000);
      5'd13:   e = mk(11'h5DA, 4'd8, 8'd20,  8'd9,  64'h00FFFF00_00000000);
      5'd14:   e = mk(11'h648, 4'd8, 8'd20,  8'd10, 64'h18FE7F00_00F0FFC3);
      5'd15:   e = mk(11'h65C, 4'd3, 8'd20,  8'd11, 64'h00000000_0000FF00);
      5'd16:   e = mk(11'h66A, 4'd8, 8'd20,  8'd12, 64'h0000C001_0100FF08);
      5'd17:   e = mk(11'h6FD, 4'd4, 8'd20,  8'd13, 64'h00000000_20990000);
      5'd18:   e = mk(11'h5E2, 4'd2, 8'd200, 8'd19, 64'h00000000_00000000);
      default: e = mk(11'h000, 4'd0, 8'd1,   8'd1,  64'h00000000_00000000);
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pcfs_phase_unit.sv
`default_nettype none
module pcfs_phase_unit
  import pcfs_pkg::*;
#(
  parameter int SLOTS     = 19,
  parameter int SLOT_W    = 5,
  parameter int TICK_WRAP = 200
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire phase_ctrl_t       ctrl,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [7:0]        period,
  input  wire logic [7:0]        phase,
  output logic                   match,
  output logic [7:0]             tick_count
);

  localparam logic [8:0] WRAP = 9'(TICK_WRAP);

  logic [7:0] cnt [SLOTS];
  logic [7:0] cur;
  logic [8:0] cur_inc;
  logic [8:0] tick_inc;
  logic       wrap;
  logic [7:0] cnt_next;
  logic [7:0] tick_next;

  always_comb begin
    cur       = cnt[slot];
    cur_inc   = {1'b0, cur} + 9'd1;
    tick_inc  = {1'b0, tick_count} + 9'd1;
    wrap      = (tick_inc == WRAP);
    cnt_next  = (wrap || cur_inc == {1'b0, period}) ? 8'd0 : cur_inc[7:0];
    tick_next = wrap ? 8'd0 : tick_inc[7:0];
    match     = (cur == phase);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < SLOTS; i++) begin
        cnt[i] <= 8'd0;
      end
      tick_count <= 8'd0;
    end else begin
      if (ctrl.update) begin
        cnt[slot] <= cnt_next;
      end
      if (ctrl.advance) begin
        tick_count <= tick_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/pcfs_frame_builder.sv
`default_nettype none
module pcfs_frame_builder
  import pcfs_pkg::*;
(
  input  wire rom_entry_t  entry,
  input  wire sensor_t     sens,
  input  wire logic [11:0] raw_speed,
  input  wire logic [13:0] rev_limit,
  output frame_t           frame,
  output logic             skip
);

  logic [7:0][7:0]   m;
  logic [1:0]        run_state;
  logic signed [9:0] clt_x;
  logic signed [9:0] iat_x;
  logic [9:0]        clt_adj;
  logic [9:0]        iat_adj;
  logic [7:0]        clt_byte;
  logic [6:0]        iat_val;
  logic [10:0]       idle_c;
  logic [12:0]       rev_c;

  always_comb begin
    run_state = (sens.q3 == 16'd0) ? 2'd0 : (sens.running ? 2'd2 : 2'd1);
    clt_x     = {sens.clt[8], sens.clt};
    iat_x     = {sens.iat[8], sens.iat};
    clt_adj   = 10'(clt_x + 10'sd40);
    iat_adj   = 10'(iat_x + 10'sd40);
    if (clt_x < -10'sd40) begin
      clt_byte = 8'd0;
    end else if (clt_x > 10'sd215) begin
      clt_byte = 8'd255;
    end else begin
      clt_byte = clt_adj[7:0];
    end
    if (iat_x < -10'sd40) begin
      iat_val = 7'd0;
    end else if (iat_x > 10'sd87) begin
      iat_val = 7'd127;
    end else begin
      iat_val = iat_adj[6:0];
    end
    idle_c = (sens.idle > IDLE_MAX) ? IDLE_MAX[10:0] : sens.idle[10:0];
    rev_c  = (rev_limit > REV_MAX) ? REV_MAX[12:0] : rev_limit[12:0];

    m = entry.base;
    case (entry.id)
      ID_ENGINE: begin
        m[0] = sens.q3[15:8];
        m[1] = sens.q3[7:0];
      end
      ID_STATE: begin
        m[2] = {run_state, m[2][5:0] & STATE_MASK[5:0]};
      end
      ID_SPEED: begin
        m[2] = (sens.q3 != 16'd0) ? SPEED_FLAG : 8'd0;
        m[3] = raw_speed[11:4];
        m[4] = {raw_speed[3:0], m[4][3:0]};
      end
      ID_COOLANT: begin
        m[0] = clt_byte;
        m[1] = idle_c[10:3];
        m[4] = rev_c[12:5];
      end
      ID_INTAKE: begin
        m[0] = {iat_val, 1'b0};
      end
      default: begin
      end
    endcase

    frame.id  = entry.id;
    frame.len = entry.len;
    for (int j = 0; j < 8; j++) begin
      frame.data[j] = (4'(j) < entry.len) ? m[j] : 8'd0;
    end
    skip = ((entry.id == ID_COOLANT) && !sens.cval) || ((entry.id == ID_INTAKE) && !sens.ival);
  end

endmodule
`default_nettype wire

>>> rtl/periodic_can_frame_scheduler_core.sv
`default_nettype none
// Periodic CAN frame scheduler. Each input transaction is one 5 ms tick with sensor readings;
// it yields up to four frame transactions, the final one flagged by last_frame. A tick passes
// through an accept step, the indicated-speed multiply, a scan of each ROM slot in turn through
// the shared phase compare and increment unit (one slot per cycle while the output register is
// not held), and a flush of the last frame. A tick arriving while enable is low produces no
// frames and clears the tick counter.
// Configuration writes are accepted in any cycle and must only be issued while the block is idle.
module periodic_can_frame_scheduler_core
  import pcfs_pkg::*;
#(
  parameter int TICK_WRAP   = 200,
  parameter int FRAME_SLOTS = 19
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [15:0]          engine_speed_q3,
  input  wire logic                 engine_running,
  input  wire logic [15:0]          road_speed_q6,
  input  wire logic signed [8:0]    coolant_temp,
  input  wire logic                 coolant_valid,
  input  wire logic signed [8:0]    intake_temp,
  input  wire logic                 intake_valid,
  input  wire logic [11:0]          idle_target_rpm,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [10:0]               frame_id,
  output logic [3:0]                data_length,
  output logic [7:0]                data_0,
  output logic [7:0]                data_1,
  output logic [7:0]                data_2,
  output logic [7:0]                data_3,
  output logic [7:0]                data_4,
  output logic [7:0]                data_5,
  output logic [7:0]                data_6,
  output logic [7:0]                data_7,
  output logic                      last_frame
);

  localparam int SLOTS  = (FRAME_SLOTS < ROM_SIZE) ? FRAME_SLOTS : ROM_SIZE;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  frame_count;
  logic              enable;
  logic [13:0]       rev_limit;
  sensor_t           sens;
  logic [15:0]       spd;
  logic [14:0]       ind;
  frame_t            pend;
  logic              pend_valid;
  frame_t            out_frame;

  logic              in_accept;
  phase_ctrl_t       pctrl;
  logic              match;
  logic [7:0]        tick_count;
  rom_entry_t        entry;
  frame_t            frame;
  logic              skip;
  logic              due;
  logic              stall;
  logic              move_ok;
  logic              take;
  logic              move;
  logic [14:0]       q6c;
  logic [29:0]       prod;
  logic [14:0]       ind_next;
  logic [17:0]       ind_x5;
  logic [12:0]       raw13;
  logic [11:0]       raw_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      rev_limit <= 14'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:    enable    <= cfg_data[0];
        CFG_REV_LIMIT: rev_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    entry     = rom_entry(ROM_IDX_W'(slot));
    q6c       = (spd > {1'b0, SPEED_MAX}) ? SPEED_MAX : spd[14:0];
    prod      = 30'(q6c) * SPEED_GAIN;
    ind_next  = (q6c == 15'd0) ? 15'd0 : 15'(prod[29:14] + 16'(SPEED_BIAS));
    ind_x5    = {1'b0, ind, 2'b00} + {3'b000, ind};
    raw13     = ind_x5[17:5];
    raw_speed = (raw13 > RAW_MAX) ? RAW_MAX[11:0] : raw13[11:0];
  end

  pcfs_phase_unit #(
    .SLOTS     (SLOTS),
    .SLOT_W    (SLOT_W),
    .TICK_WRAP (TICK_WRAP)
  ) u_phase (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pctrl),
    .slot       (slot),
    .period     (entry.period),
    .phase      (entry.phase),
    .match      (match),
    .tick_count (tick_count)
  );

  pcfs_frame_builder u_build (
    .entry     (entry),
    .sens      (sens),
    .raw_speed (raw_speed),
    .rev_limit (rev_limit),
    .frame     (frame),
    .skip      (skip)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && enable) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!stall && slot == LAST_SLOT) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!pend_valid || move_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    in_accept     = in_valid && in_ready;
    move_ok       = !out_valid || out_ready;
    due           = (state == S_SCAN) && match && !skip && (frame_count < CNT_W'(MAX_OUT));
    stall         = due && pend_valid && !move_ok;
    take          = due && !stall;
    move          = (take && pend_valid) || ((state == S_FINISH) && pend_valid && move_ok);
    pctrl.clear   = in_accept && !enable;
    pctrl.update  = (state == S_SCAN) && !stall;
    pctrl.advance = pctrl.update && (slot == LAST_SLOT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot        <= '0;
      frame_count <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PREP) begin
        slot        <= '0;
        frame_count <= '0;
      end else if (pctrl.update && slot != LAST_SLOT) begin
        slot <= slot + 1'b1;
      end
      if (take) begin
        frame_count <= frame_count + 1'b1;
        pend_valid  <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sens.q3      <= engine_speed_q3;
      sens.running <= engine_running;
      sens.clt     <= coolant_temp;
      sens.cval    <= coolant_valid;
      sens.iat     <= intake_temp;
      sens.ival    <= intake_valid;
      sens.idle    <= idle_target_rpm;
      spd          <= road_speed_q6;
    end
    if (state == S_PREP) begin
      ind <= ind_next;
    end
    if (take) begin
      pend <= frame;
    end
    if (move) begin
      out_frame  <= pend;
      last_frame <= (state == S_FINISH);
    end
  end

  assign frame_id    = out_frame.id;
  assign data_length = out_frame.len;
  assign data_0      = out_frame.data[0];
  assign data_1      = out_frame.data[1];
  assign data_2      = out_frame.data[2];
  assign data_3      = out_frame.data[3];
  assign data_4      = out_frame.data[4];
  assign data_5      = out_frame.data[5];
  assign data_6      = out_frame.data[6];
  assign data_7      = out_frame.data[7];

  assert property (@(posedge clk) disable iff (rst) frame_count <= CNT_W'(MAX_OUT))
    else $error("frame count exceeds limit");

  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !pend_valid)
    else $error("pending frame left behind at idle");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !enable) |=> (tick_count == 8'd0))
    else $error("disabled tick did not clear counter");

endmodule
`default_nettype wire
